// ===== rtl/core/sgl_pkg.sv =====
// shared types and constants for the shift-jis glyph index lookup
package sgl_pkg;

  localparam int unsigned TableWords = 4096;
  localparam int unsigned TableAw    = $clog2(TableWords);
  localparam int unsigned MaxRanges  = 64;
  localparam int unsigned CntW       = $clog2(MaxRanges + 1);

  localparam int unsigned CodeW   = 16;
  localparam int unsigned WordW   = 16;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned WordsW  = 8;
  localparam int unsigned ProdW   = WordsW + IndexW;

  // tdata layouts, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [0:0] {
    CfgGlyphBase  = 1'b0,
    CfgGlyphWords = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CmdLookup = 1'b0,
    CmdWrite  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [AddrW-1:0]  glyph_base;
    logic [WordsW-1:0] glyph_words;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] glyph_index;
    logic [AddrW-1:0]  glyph_address;
  } res_t;

endpackage

// ===== rtl/core/sjis_glyph_index_lookup.sv =====
// top level: stream ports, configuration registers and output register
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: code, table_address, table_data
//                                              tuser: command
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: glyph_index, glyph_address
//                                              tuser: found
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// a write item and a code of zero go from the accept state to multiply and result;
// a lookup does one table read per state in between (level 1, level 2, count, one
// per range tried, offset), stopping early on a zero word or a miss.
// all table reads share the single port of the table ram.
// the result sits in an output register, so the next item is taken while it waits.
// reset clears the configuration to base 0 and 30 words; the table is not cleared.
module sjis_glyph_index_lookup
  import sgl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // code, table_address, table_data, pad
  input  logic                 s_axis_tuser,   // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // glyph_index, glyph_address
  output logic                 m_axis_tuser,   // found
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [AddrW-1:0]     cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  res_t out_q;
  logic out_valid_q, out_valid_d;
  logic res_valid;
  logic res_ready;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgGlyphBase:  cfg_d.glyph_base  = cfg_data_i;
        CfgGlyphWords: cfg_d.glyph_words = cfg_data_i[WordsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_base  <= '0;
      cfg_q.glyph_words <= WordsW'(30);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sgl_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .command_i       (s_axis_tuser),
    .code_i          (s_axis_tdata[15:0]),
    .table_address_i (s_axis_tdata[27:16]),
    .table_data_i    (s_axis_tdata[43:28]),
    .cfg_i           (cfg_q),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // output slot frees up in the same cycle the held item is taken
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {out_q.glyph_address, out_q.glyph_index};

endmodule

// ===== rtl/core/sgl_ram.sv =====
// generic single-port synchronous ram with registered read
module sgl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sgl_ctrl.sv =====
// lookup sequencer: walks the code table in memory and forms the result
module sgl_ctrl
  import sgl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [CodeW-1:0]    code_i,
  input  logic [TableAw-1:0]  table_address_i,
  input  logic [WordW-1:0]    table_data_i,
  input  cfg_t                cfg_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StL1   = 8'b0000_0010,
    StL2   = 8'b0000_0100,
    StCnt  = 8'b0000_1000,
    StSe   = 8'b0001_0000,
    StOfs  = 8'b0010_0000,
    StMul  = 8'b0100_0000,
    StDone = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         lo_q, lo_d;
  logic [TableAw-1:0] ptr_q, ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    k_q, k_d;
  logic [5:0]         diff_q, diff_d;
  logic               found_q, found_d;
  logic               wr_q, wr_d;
  logic [IndexW-1:0]  idx_q, idx_d;
  logic [ProdW-1:0]   prod_q, prod_d;

  logic               ram_we;
  logic [TableAw-1:0] ram_addr;
  logic [WordW-1:0]   ram_wdata;
  logic [WordW-1:0]   rdata;

  logic [7:0]         c8;
  logic [7:0]         se_start;
  logic [7:0]         se_end;
  logic [CntW-1:0]    k_next;

  sgl_ram #(
    .Width (WordW),
    .Depth (TableWords)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  assign c8       = {2'b00, lo_q[5:0]};
  assign se_start = rdata[7:0];
  assign se_end   = rdata[15:8];
  assign k_next   = k_q + CntW'(1);

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    diff_d    = diff_q;
    found_d   = found_q;
    wr_d      = wr_q;
    idx_d     = idx_q;
    prod_d    = prod_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = table_data_i;

    case (state_q)
      StIdle: begin
        // level-1 slot folded from the lead byte
        ram_addr = TableAw'({code_i[14], code_i[12:8]});
        if (in_valid_i) begin
          lo_d    = code_i[7:0];
          found_d = 1'b0;
          idx_d   = '0;
          wr_d    = 1'b0;
          if (command_i == CmdWrite) begin
            ram_we   = 1'b1;
            ram_addr = table_address_i;
            wr_d     = 1'b1;
            state_d  = StMul;
          end else if (code_i == '0) begin
            found_d = 1'b1;
            state_d = StMul;
          end else begin
            state_d = StL1;
          end
        end
      end
      StL1: begin
        ram_addr = rdata[TableAw:1] + TableAw'(lo_q[7:6]);
        state_d  = (rdata == '0) ? StMul : StL2;
      end
      StL2: begin
        ram_addr = rdata[TableAw:1];
        ptr_d    = rdata[TableAw:1];
        state_d  = (rdata == '0) ? StMul : StCnt;
      end
      StCnt: begin
        // first start/end word of the list
        ram_addr = ptr_q + TableAw'(1);
        ptr_d    = ptr_q + TableAw'(1);
        k_d      = '0;
        if (rdata > WordW'(MaxRanges)) begin
          cnt_d = CntW'(MaxRanges);
        end else begin
          cnt_d = rdata[CntW-1:0];
        end
        state_d = (rdata == '0) ? StMul : StSe;
      end
      StSe: begin
        if (c8 >= se_start && c8 <= se_end) begin
          ram_addr = ptr_q + TableAw'(1);
          diff_d   = 6'(c8 - se_start);
          state_d  = StOfs;
        end else begin
          ram_addr = ptr_q + TableAw'(2);
          ptr_d    = ptr_q + TableAw'(2);
          k_d      = k_next;
          state_d  = (k_next == cnt_q) ? StMul : StSe;
        end
      end
      StOfs: begin
        idx_d   = rdata + IndexW'(diff_q);
        found_d = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        prod_d  = ProdW'(cfg_i.glyph_words) * ProdW'(idx_q);
        state_d = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    ptr_q   <= ptr_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    diff_q  <= diff_d;
    found_q <= found_d;
    wr_q    <= wr_d;
    idx_q   <= idx_d;
    prod_q  <= prod_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);

  always_comb begin
    res_o.found       = found_q;
    res_o.glyph_index = idx_q;
    if (wr_q) begin
      res_o.glyph_address = '0;
    end else begin
      res_o.glyph_address = cfg_i.glyph_base + AddrW'({prod_q, 1'b0});
    end
  end

endmodule

// ===== sim/glyph_lookup_checker.sv =====
// watches the item streams and the register channel, predicts every result and compares it
module glyph_lookup_checker
  import sgl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // code, table_address, table_data, pad
  input  logic                s_axis_tuser,   // command
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // glyph_index, glyph_address
  input  logic                m_axis_tuser,   // found
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [AddrW-1:0]    cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  logic [WordW-1:0]  table_copy [TableWords];
  logic [AddrW-1:0]  glyph_base_q;
  logic [WordsW-1:0] glyph_words_q;
  res_t              pending_glyphs [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [48:0] got,
                                 input logic [48:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // walk level 1, level 2 and the range list the way the block does
  function automatic res_t lookup_glyph(input logic [CodeW-1:0] code);
    res_t              r;
    logic [TableAw-1:0] lst;
    logic [WordW-1:0]  w;
    logic [IndexW-1:0] idx;
    logic [5:0]        c;
    logic              hit;
    int unsigned       n, k;
    hit = 1'b0;
    idx = '0;
    if (code == '0) begin
      hit = 1'b1;
    end else begin
      w = table_copy[{code[14], code[12:8]}];
      if (w != '0) begin
        w = table_copy[w[12:1] + TableAw'(code[7:6])];
        if (w != '0) begin
          lst = w[12:1];
          n = (table_copy[lst] > MaxRanges) ? MaxRanges : table_copy[lst];
          c = code[5:0];
          for (k = 0; k < n && !hit; k++) begin
            w = table_copy[lst + TableAw'(2 * k + 1)];
            if (c >= w[7:0] && c <= w[15:8]) begin
              idx = table_copy[lst + TableAw'(2 * k + 2)] + IndexW'(c - w[7:0]);
              hit = 1'b1;
            end
          end
        end
      end
    end
    r.found = hit;
    r.glyph_index = idx;
    r.glyph_address = glyph_base_q + 32'(2 * glyph_words_q * idx);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    res_t got, want;
    if (!rst_ni) begin
      glyph_base_q = '0;
      glyph_words_q = 8'd30;
      pending_glyphs.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgGlyphBase) begin
          glyph_base_q = cfg_data_i;
        end else begin
          glyph_words_q = cfg_data_i[WordsW-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CmdWrite) begin
          table_copy[s_axis_tdata[27:16]] = s_axis_tdata[43:28];
          pending_glyphs.push_back('0);
        end else begin
          pending_glyphs.push_back(lookup_glyph(s_axis_tdata[15:0]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser;
        got.glyph_index = m_axis_tdata[15:0];
        got.glyph_address = m_axis_tdata[47:16];
        if (pending_glyphs.size() == 0) begin
          report_mismatch("result with no item pending", got, '0);
        end else begin
          want = pending_glyphs.pop_front();
          if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
          if (got.glyph_index !== want.glyph_index)
            report_mismatch("glyph_index", got.glyph_index, want.glyph_index);
          if (got.glyph_address !== want.glyph_address)
            report_mismatch("glyph_address", got.glyph_address, want.glyph_address);
        end
      end
      pending_o <= int'(pending_glyphs.size());
    end
  end

endmodule

// ===== sim/sjis_glyph_index_lookup_tb.sv =====
// stimulus and verdict for the shift-jis glyph index lookup
module sjis_glyph_index_lookup_tb
  import sgl_pkg::*;
;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire [OutDataW-1:0]  m_axis_tdata;
  wire                 m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  wire                 cfg_ready_o;
  logic                cfg_index_i = 1'b0;
  logic [AddrW-1:0]    cfg_data_i = '0;

  int pending_cnt;
  int fail_count;
  int send_idle_pct = 8;
  int recv_idle_pct = 69;
  int items = 0;
  int next_free = 64;

  // what has been written so far, so a lookup never touches an unwritten word
  logic [WordW-1:0] table_image [TableWords];
  bit               table_known [TableWords];

  sjis_glyph_index_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  glyph_lookup_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending_cnt),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // first word on the read path of a lookup that was never written, or -1
  function automatic int first_unwritten_word(input logic [CodeW-1:0] code);
    logic [TableAw-1:0] wa, lst;
    logic [WordW-1:0]   w;
    logic [5:0]         c;
    int unsigned        n, k;
    if (code == '0) return -1;
    wa = {code[14], code[12:8]};
    if (!table_known[wa]) return int'(wa);
    w = table_image[wa];
    if (w == '0) return -1;
    wa = w[12:1] + TableAw'(code[7:6]);
    if (!table_known[wa]) return int'(wa);
    w = table_image[wa];
    if (w == '0) return -1;
    lst = w[12:1];
    if (!table_known[lst]) return int'(lst);
    n = (table_image[lst] > MaxRanges) ? MaxRanges : table_image[lst];
    c = code[5:0];
    for (k = 0; k < n; k++) begin
      wa = lst + TableAw'(2 * k + 1);
      if (!table_known[wa]) return int'(wa);
      w = table_image[wa];
      if (c >= w[7:0] && c <= w[15:8]) begin
        wa = wa + 1'b1;
        return table_known[wa] ? -1 : int'(wa);
      end
    end
    return -1;
  endfunction

  function automatic int take_words(input int size);
    int at;
    if (next_free + size > TableWords) next_free = 64;
    at = next_free;
    next_free += size;
    return at;
  endfunction

  // pointer words hold byte offsets; add odd bits and copies beyond the table at random
  function automatic logic [WordW-1:0] byte_offset(input int wa);
    int wrap;
    wrap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    return WordW'(((wa + wrap * TableWords) << 1) | $urandom_range(0, 1));
  endfunction

  // valid stays high after acceptance; the next call replaces or lowers it
  task automatic send_item(input cmd_e cmd, input logic [15:0] code,
                           input logic [11:0] taddr, input logic [15:0] tdata);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, tdata, taddr, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CmdWrite) begin
      table_image[taddr] = tdata;
      table_known[taddr] = 1'b1;
    end
    items++;
  endtask

  task automatic put_word(input logic [11:0] addr, input logic [15:0] data);
    send_item(CmdWrite, 16'($urandom), addr, data);
  endtask

  task automatic look_up(input logic [15:0] code);
    int hole;
    hole = first_unwritten_word(code);
    while (hole >= 0) begin
      put_word(hole[11:0], ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0);
      hole = first_unwritten_word(code);
    end
    send_item(CmdLookup, code, 12'($urandom), 16'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [AddrW-1:0] base, input logic [WordsW-1:0] words);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgGlyphBase;
    cfg_data_i <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgGlyphWords;
    cfg_data_i <= AddrW'(words);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase, goal, r, e, k, blk, lst, n;
    int unsigned cnt;
    logic [7:0]  hi, st, ed;
    logic [AddrW-1:0] base;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-built table under the reset configuration
    look_up(16'h0000);
    put_word(12'h001, 16'h0000);
    look_up(16'h8100);
    put_word(12'h001, 16'h0101);
    put_word(12'h080, 16'h0200);
    put_word(12'h081, 16'h0000);
    put_word(12'h082, 16'h2281);
    put_word(12'h083, 16'h1ffc);
    put_word(12'h100, 16'd2);
    put_word(12'h101, 16'h0f00);
    put_word(12'h102, 16'h0010);
    put_word(12'h103, 16'h3f20);
    put_word(12'h104, 16'hfff0);
    put_word(12'h140, 16'h0000);
    // list at the top of the table whose offset word wraps to word zero
    put_word(12'hffe, 16'h0001);
    put_word(12'hfff, 16'h3f01);
    put_word(12'h000, 16'h0000);
    look_up(16'h8100);
    look_up(16'h810f);
    look_up(16'h8115);
    look_up(16'h813f);
    look_up(16'h8150);
    look_up(16'h81a5);
    look_up(16'h81ff);
    look_up(16'hffff);

    for (phase = 0; phase < 3; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 69;
          set_config(32'hffff_ffff, 8'd255);
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 8;
          set_config(32'($urandom), 8'd1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_config('0, 8'($urandom_range(1, 255)));
        end
      endcase
      goal = items + 570;
      while (items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // a well-formed lead byte: level-1 word, four level-2 words, range lists
          hi = 8'($urandom);
          blk = take_words(4);
          put_word({6'b0, hi[6], hi[4:0]}, byte_offset(blk));
          for (e = 0; e < 4; e++) begin
            if ($urandom_range(0, 7) == 0) begin
              put_word(12'(blk + e), 16'h0);
            end else begin
              k = $urandom_range(0, 19);
              if (k == 0) begin
                n = MaxRanges;
                cnt = ($urandom_range(0, 1) == 0) ? MaxRanges : $urandom_range(65, 65535);
              end else if (k == 1) begin
                n = $urandom_range(6, 30);
                cnt = n;
              end else begin
                n = $urandom_range(0, 5);
                cnt = n;
              end
              lst = take_words(1 + 2 * n);
              put_word(12'(blk + e), byte_offset(lst));
              put_word(12'(lst), 16'(cnt));
              for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                  st = 8'($urandom);
                  ed = 8'($urandom);
                end else begin
                  st = 8'($urandom_range(0, 63));
                  ed = st + 8'($urandom_range(0, 12));
                end
                put_word(12'(lst + 1 + 2 * k), {ed, st});
                put_word(12'(lst + 2 + 2 * k), ($urandom_range(0, 7) == 0) ?
                         16'(16'hffff - $urandom_range(0, 20)) : 16'($urandom));
              end
            end
          end
          repeat ($urandom_range(4, 12)) look_up({hi, 8'($urandom)});
        end else if (r < 82) begin
          look_up(16'($urandom));
        end else if (r < 95) begin
          put_word(12'($urandom), 16'($urandom));
        end else if (r < 98) begin
          drain_results();
        end else begin
          drain_results();
          case ($urandom_range(0, 3))
            0: base = '0;
            1: base = 32'hffff_ffff;
            default: base = 32'($urandom);
          endcase
          set_config(base, 8'($urandom_range(1, 255)));
        end
      end
    end

    drain_results();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
